// ===== design/fbmvn_pkg.sv =====
// shared constants, types and helper functions of the fractal value noise block
`default_nettype none

package fbmvn_pkg;

  // fixed-point format and octave limit
  localparam int FRAC_BITS   = 16;
  localparam int MAX_OCTAVES = 8;
  localparam int ONE_Q       = 1 << FRAC_BITS;

  // port widths
  localparam int COORD_W = 32;
  localparam int SEED_W  = 32;
  localparam int CNT_W   = 4;
  localparam int VAL_W   = FRAC_BITS + 2;

  // internal widths
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int HASH_W  = 32;
  localparam int SPLIT_W = COORD_W + FRAC_BITS;
  localparam int NVAL_W  = FRAC_BITS + 32;
  localparam int UX_W    = FRAC_BITS + 1;
  localparam int OCT_W   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int NCNT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int WSUM_W  = MAX_OCTAVES;
  localparam int ACC_W   = FRAC_BITS + 2 + MAX_OCTAVES;
  localparam int QUO_W   = FRAC_BITS + 1;

  // hash constants
  localparam logic [HASH_W-1:0] HASH_PX   = 32'd374761393;
  localparam logic [HASH_W-1:0] HASH_PY   = 32'd668265263;
  localparam logic [HASH_W-1:0] HASH_PS   = 32'd1013904223;
  localparam logic [HASH_W-1:0] HASH_PD   = 32'd1274126177;
  localparam logic [HASH_W-1:0] HASH_PYMX = HASH_PY - HASH_PX;
  localparam logic [HASH_W-1:0] SEED_STEP = 32'd1000;
  localparam logic [30:0]       H31_MAX   = 31'h7FFFFFFF;
  localparam logic [NVAL_W-1:0] H31_BIAS  = NVAL_W'(32'h3FFFFFFF);

  // divider handshake
  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] acc;
    logic [WSUM_W-1:0]       den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] quo;
  } div_rsp_t;

  // first xorshift of the hash, before the final multiply
  function automatic logic [HASH_W-1:0] hash_mix(input logic [HASH_W-1:0] h);
    return h ^ (h >> 13);
  endfunction

  // last xorshift of the hash
  function automatic logic [HASH_W-1:0] hash_fin(input logic [HASH_W-1:0] h);
    return h ^ (h >> 16);
  endfunction

  // scaled numerator of the 31-bit to [-1,1] mapping, rounding bias included
  function automatic logic [NVAL_W-1:0] corner_num(input logic [HASH_W-1:0] h);
    return {h[30:0], {(FRAC_BITS + 1){1'b0}}} + H31_BIAS;
  endfunction

  // divide by 2^31-1: quotient is the high part plus one compare correction
  function automatic logic signed [VAL_W-1:0] corner_val(input logic [NVAL_W-1:0] n);
    logic [FRAC_BITS:0] hi;
    logic [31:0]        s;
    logic [VAL_W-1:0]   q;
    hi = n[NVAL_W-1:31];
    s  = 32'(hi) + 32'(n[30:0]);
    q  = VAL_W'(hi) + VAL_W'(s >= 32'(H31_MAX));
    return $signed(q - VAL_W'(ONE_Q));
  endfunction

  // 6t - 15 for the quintic fade
  function automatic logic signed [MUL_W-1:0] fade_k(input logic [FRAC_BITS-1:0] t);
    logic signed [MUL_W-1:0] tt;
    tt = $signed(MUL_W'(t));
    return (tt <<< 2) + (tt <<< 1) - MUL_W'(15 * ONE_Q);
  endfunction

  // clamp a fade result to [0,1]
  function automatic logic [UX_W-1:0] fade_clamp(input logic signed [MUL_W-1:0] r);
    logic [UX_W-1:0] u;
    if (r < 0) begin
      u = '0;
    end else if (r > ONE_Q) begin
      u = UX_W'(ONE_Q);
    end else begin
      u = r[UX_W-1:0];
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== design/fbm_value_noise_2d_top.sv =====
// top level: octave sequencer, lattice hash and fade datapath around the shared multiplier
`default_nettype none

// Fractal value noise at one 2D point. An item carries x and y in signed Q15.16,
// a 32-bit seed and an octave count (zero is taken as one, counts above eight as
// eight); the result item is the normalized noise in signed Q1.16, within [-1,1].
// The block works on one item at a time and holds in_stall_o high until that
// item's result has moved to the output register, which lets the next item in
// while the previous result still waits for out_stall_i to drop.
// Each octave is a 24-step schedule of 18 products on the single shared 32x32
// multiplier (hash products, fade polynomial, three lerps); the normalization is
// a restoring divide that produces one quotient bit per cycle (17 bits), and its
// result then moves through a result register into the output register.
module fbm_value_noise_2d_top (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [fbmvn_pkg::COORD_W-1:0]  x_coord_i,
  input  wire logic signed [fbmvn_pkg::COORD_W-1:0]  y_coord_i,
  input  wire logic signed [fbmvn_pkg::SEED_W-1:0]   noise_seed_i,
  input  wire logic [fbmvn_pkg::CNT_W-1:0]           octave_count_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [fbmvn_pkg::VAL_W-1:0]         noise_value_o
);

  // top-level states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // steps of one octave
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] S_SPLIT   = 5'd0;
  localparam logic [STEP_W-1:0] S_MUL_XA  = 5'd1;
  localparam logic [STEP_W-1:0] S_MUL_YB  = 5'd2;
  localparam logic [STEP_W-1:0] S_MUL_SC  = 5'd3;
  localparam logic [STEP_W-1:0] S_FADE_X0 = 5'd4;
  localparam logic [STEP_W-1:0] S_FADE_Y0 = 5'd5;
  localparam logic [STEP_W-1:0] S_HASH00  = 5'd6;
  localparam logic [STEP_W-1:0] S_HASH10  = 5'd7;
  localparam logic [STEP_W-1:0] S_HASH01  = 5'd8;
  localparam logic [STEP_W-1:0] S_HASH11  = 5'd9;
  localparam logic [STEP_W-1:0] S_FADE_X1 = 5'd10;
  localparam logic [STEP_W-1:0] S_FADE_Y1 = 5'd11;
  localparam logic [STEP_W-1:0] S_FADE_X2 = 5'd12;
  localparam logic [STEP_W-1:0] S_FADE_Y2 = 5'd13;
  localparam logic [STEP_W-1:0] S_FADE_X3 = 5'd14;
  localparam logic [STEP_W-1:0] S_FADE_Y3 = 5'd15;
  localparam logic [STEP_W-1:0] S_LERP_X0 = 5'd16;
  localparam logic [STEP_W-1:0] S_LERP_X1 = 5'd17;
  localparam logic [STEP_W-1:0] S_NX0     = 5'd18;
  localparam logic [STEP_W-1:0] S_NX1     = 5'd19;
  localparam logic [STEP_W-1:0] S_LERP_Y  = 5'd20;
  localparam logic [STEP_W-1:0] S_NOISE   = 5'd22;
  localparam logic [STEP_W-1:0] S_ACC     = 5'd23;

  // control registers
  logic [1:0]                       state_q, state_d;
  logic [STEP_W-1:0]                step_q, step_d;
  logic [fbmvn_pkg::OCT_W-1:0]      oct_q, oct_d;
  logic [fbmvn_pkg::NCNT_W-1:0]     n_q, n_d;
  logic                             div_go_q, div_go_d;
  logic                             out_valid_q, out_valid_d;

  // item and datapath registers
  logic signed [fbmvn_pkg::COORD_W-1:0] x_q, y_q;
  logic [fbmvn_pkg::HASH_W-1:0]         oct_seed_q;
  logic [fbmvn_pkg::HASH_W-1:0]         xi_q, yi_q;
  logic [fbmvn_pkg::FRAC_BITS-1:0]      xf_q, yf_q;
  logic [fbmvn_pkg::HASH_W-1:0]         hx_q, hy_q, hs_q, hsum_q;
  logic [fbmvn_pkg::HASH_W-1:0]         hf_q;
  logic [fbmvn_pkg::NVAL_W-1:0]         cnum_q;
  logic signed [fbmvn_pkg::VAL_W-1:0]   corner_q [4];
  logic signed [fbmvn_pkg::MUL_W-1:0]   bx_q, by_q;
  logic [fbmvn_pkg::UX_W-1:0]           ux_q, vy_q;
  logic signed [fbmvn_pkg::VAL_W-1:0]   nx0_q, nx1_q, nv_q;
  logic signed [fbmvn_pkg::ACC_W-1:0]   acc_q;
  logic [fbmvn_pkg::WSUM_W-1:0]         wsum_q;
  logic signed [fbmvn_pkg::VAL_W-1:0]   res_q;
  logic signed [fbmvn_pkg::VAL_W-1:0]   noise_q;

  // combinational helpers
  logic                                 in_acc;
  logic                                 out_free;
  logic                                 last_oct;
  logic                                 running;
  logic [fbmvn_pkg::NCNT_W-1:0]         n_in;
  logic signed [fbmvn_pkg::SPLIT_W-1:0] x_sh, y_sh;
  logic [fbmvn_pkg::OCT_W-1:0]          wshift;
  logic signed [fbmvn_pkg::VAL_W:0]     dx0, dx1, dy;
  logic signed [fbmvn_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [fbmvn_pkg::PROD_W-1:0]  mul_prod;
  logic signed [fbmvn_pkg::MUL_W-1:0]   mul_rnd;
  fbmvn_pkg::div_req_t                  div_req;
  fbmvn_pkg::div_rsp_t                  div_rsp;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign running  = (state_q == ST_RUN);
  assign last_oct = (fbmvn_pkg::NCNT_W'(oct_q) + fbmvn_pkg::NCNT_W'(1)) == n_q;
  assign wshift   = fbmvn_pkg::OCT_W'(fbmvn_pkg::MAX_OCTAVES - 1) - oct_q;

  // octave count: zero means one, saturate at the maximum
  always_comb begin
    if (octave_count_i == '0) begin
      n_in = fbmvn_pkg::NCNT_W'(1);
    end else if (int'(octave_count_i) > fbmvn_pkg::MAX_OCTAVES) begin
      n_in = fbmvn_pkg::NCNT_W'(fbmvn_pkg::MAX_OCTAVES);
    end else begin
      n_in = fbmvn_pkg::NCNT_W'(octave_count_i);
    end
  end

  // point scaled by 2^octave, split into lattice cell and fraction
  assign x_sh = fbmvn_pkg::SPLIT_W'(x_q) <<< oct_q;
  assign y_sh = fbmvn_pkg::SPLIT_W'(y_q) <<< oct_q;

  // corner differences for the lerps
  assign dx0 = (fbmvn_pkg::VAL_W + 1)'(corner_q[1]) - (fbmvn_pkg::VAL_W + 1)'(corner_q[0]);
  assign dx1 = (fbmvn_pkg::VAL_W + 1)'(corner_q[3]) - (fbmvn_pkg::VAL_W + 1)'(corner_q[2]);
  assign dy  = (fbmvn_pkg::VAL_W + 1)'(nx1_q) - (fbmvn_pkg::VAL_W + 1)'(nx0_q);

  // multiplier operand select per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (running) begin
      case (step_q)
        S_MUL_XA: begin
          mul_a = $signed(xi_q);
          mul_b = $signed(fbmvn_pkg::HASH_PX);
        end
        S_MUL_YB: begin
          mul_a = $signed(yi_q);
          mul_b = $signed(fbmvn_pkg::HASH_PY);
        end
        S_MUL_SC: begin
          mul_a = $signed(oct_seed_q);
          mul_b = $signed(fbmvn_pkg::HASH_PS);
        end
        S_FADE_X0: begin
          mul_a = $signed(fbmvn_pkg::MUL_W'(xf_q));
          mul_b = fbmvn_pkg::fade_k(xf_q);
        end
        S_FADE_Y0: begin
          mul_a = $signed(fbmvn_pkg::MUL_W'(yf_q));
          mul_b = fbmvn_pkg::fade_k(yf_q);
        end
        S_HASH00, S_HASH10, S_HASH01, S_HASH11: begin
          mul_a = $signed(fbmvn_pkg::hash_mix(hsum_q));
          mul_b = $signed(fbmvn_pkg::HASH_PD);
        end
        S_FADE_X1: begin
          mul_a = $signed(fbmvn_pkg::MUL_W'(xf_q));
          mul_b = bx_q;
        end
        S_FADE_Y1: begin
          mul_a = $signed(fbmvn_pkg::MUL_W'(yf_q));
          mul_b = by_q;
        end
        S_FADE_X2, S_FADE_X3: begin
          mul_a = $signed(fbmvn_pkg::MUL_W'(xf_q));
          mul_b = mul_rnd;
        end
        S_FADE_Y2, S_FADE_Y3: begin
          mul_a = $signed(fbmvn_pkg::MUL_W'(yf_q));
          mul_b = mul_rnd;
        end
        S_LERP_X0: begin
          mul_a = fbmvn_pkg::MUL_W'(dx0);
          mul_b = $signed(fbmvn_pkg::MUL_W'(fbmvn_pkg::fade_clamp(mul_rnd)));
        end
        S_LERP_X1: begin
          mul_a = fbmvn_pkg::MUL_W'(dx1);
          mul_b = $signed(fbmvn_pkg::MUL_W'(ux_q));
        end
        S_LERP_Y: begin
          mul_a = fbmvn_pkg::MUL_W'(dy);
          mul_b = $signed(fbmvn_pkg::MUL_W'(vy_q));
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  // shared multiplier
  fbmvn_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod),
    .rnd_o  (mul_rnd)
  );

  // normalizing divider
  assign div_req.start = div_go_q;
  assign div_req.acc   = acc_q;
  assign div_req.den   = wsum_q;

  fbmvn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    oct_d       = oct_q;
    n_d         = n_q;
    div_go_d    = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RUN;
          step_d  = S_SPLIT;
          oct_d   = '0;
          n_d     = n_in;
        end
      end
      ST_RUN: begin
        if (step_q == S_ACC) begin
          step_d = S_SPLIT;
          if (last_oct) begin
            state_d  = ST_DIV;
            div_go_d = 1'b1;
          end else begin
            oct_d = oct_q + 1'b1;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= S_SPLIT;
      oct_q       <= '0;
      n_q         <= '0;
      div_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      oct_q       <= oct_d;
      n_q         <= n_d;
      div_go_q    <= div_go_d;
      out_valid_q <= out_valid_d;
    end
  end

  // hash finish and corner numerator run every cycle
  always_ff @(posedge clk_i) begin
    hf_q   <= fbmvn_pkg::hash_fin(mul_prod[fbmvn_pkg::HASH_W-1:0]);
    cnum_q <= fbmvn_pkg::corner_num(hf_q);
  end

  // item capture and per-step datapath updates
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q        <= x_coord_i;
      y_q        <= y_coord_i;
      oct_seed_q <= noise_seed_i;
      acc_q      <= '0;
      wsum_q     <= '0;
    end
    if (running) begin
      case (step_q)
        S_SPLIT: begin
          xi_q <= x_sh[fbmvn_pkg::SPLIT_W-1:fbmvn_pkg::FRAC_BITS];
          yi_q <= y_sh[fbmvn_pkg::SPLIT_W-1:fbmvn_pkg::FRAC_BITS];
          xf_q <= x_sh[fbmvn_pkg::FRAC_BITS-1:0];
          yf_q <= y_sh[fbmvn_pkg::FRAC_BITS-1:0];
        end
        S_MUL_YB: begin
          hx_q <= mul_prod[fbmvn_pkg::HASH_W-1:0];
        end
        S_MUL_SC: begin
          hy_q <= mul_prod[fbmvn_pkg::HASH_W-1:0];
        end
        S_FADE_X0: begin
          hs_q <= mul_prod[fbmvn_pkg::HASH_W-1:0];
        end
        S_FADE_Y0: begin
          hsum_q <= hx_q + hy_q + hs_q;
        end
        S_HASH00: begin
          hsum_q <= hsum_q + fbmvn_pkg::HASH_PX;
          bx_q   <= mul_rnd + fbmvn_pkg::MUL_W'(10 * fbmvn_pkg::ONE_Q);
        end
        S_HASH10: begin
          hsum_q <= hsum_q + fbmvn_pkg::HASH_PYMX;
          by_q   <= mul_rnd + fbmvn_pkg::MUL_W'(10 * fbmvn_pkg::ONE_Q);
        end
        S_HASH01: begin
          hsum_q <= hsum_q + fbmvn_pkg::HASH_PX;
        end
        S_LERP_X0: begin
          ux_q <= fbmvn_pkg::fade_clamp(mul_rnd);
        end
        S_LERP_X1: begin
          vy_q <= fbmvn_pkg::fade_clamp(mul_rnd);
        end
        S_NX0: begin
          nx0_q <= corner_q[0] + mul_rnd[fbmvn_pkg::VAL_W-1:0];
        end
        S_NX1: begin
          nx1_q <= corner_q[2] + mul_rnd[fbmvn_pkg::VAL_W-1:0];
        end
        S_NOISE: begin
          nv_q <= nx0_q + mul_rnd[fbmvn_pkg::VAL_W-1:0];
        end
        S_ACC: begin
          acc_q      <= acc_q + (fbmvn_pkg::ACC_W'(nv_q) <<< wshift);
          wsum_q     <= wsum_q + (fbmvn_pkg::WSUM_W'(1) << wshift);
          oct_seed_q <= oct_seed_q + fbmvn_pkg::SEED_STEP;
        end
        default: begin
        end
      endcase
      // corner values arrive in order 00, 10, 01, 11 and shift down
      if (step_q inside {[S_HASH11:S_FADE_X2]}) begin
        corner_q[3] <= fbmvn_pkg::corner_val(cnum_q);
        corner_q[2] <= corner_q[3];
        corner_q[1] <= corner_q[2];
        corner_q[0] <= corner_q[1];
      end
    end
    if (div_rsp.done) begin
      res_q <= div_rsp.quo;
    end
    if (state_q == ST_OUT && out_free) begin
      noise_q <= res_q;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

`ifndef ASSERT_OFF
  // an accepted item starts a fresh sum at the first octave
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RUN && step_q == S_SPLIT && oct_q == '0 &&
                acc_q == '0 && wsum_q == '0))
    else $error("item accepted without a clean start");

  // the octave index never runs past the requested count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (running && step_q == S_ACC) |-> (fbmvn_pkg::NCNT_W'(oct_q) < n_q))
    else $error("octave index beyond count");

  // normalization starts only after the last octave
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_go_q |-> (state_q == ST_DIV && $past(step_q) == S_ACC))
    else $error("divider started out of sequence");

  // a result item stays within [-1,1]
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (noise_value_o <= fbmvn_pkg::ONE_Q && noise_value_o >= -fbmvn_pkg::ONE_Q))
    else $error("noise value out of range");
`endif

endmodule

`default_nettype wire

// ===== design/fbmvn_mul.sv =====
// shared signed multiplier with registered product and registered fixed-point rounding
`default_nettype none

module fbmvn_mul (
  input  wire logic                                clk_i,
  input  wire logic signed [fbmvn_pkg::MUL_W-1:0]  a_i,
  input  wire logic signed [fbmvn_pkg::MUL_W-1:0]  b_i,
  output logic signed [fbmvn_pkg::PROD_W-1:0]      prod_o,
  output logic signed [fbmvn_pkg::MUL_W-1:0]       rnd_o
);

  localparam logic [fbmvn_pkg::PROD_W-1:0] HALF =
    fbmvn_pkg::PROD_W'(1) << (fbmvn_pkg::FRAC_BITS - 1);

  logic signed [fbmvn_pkg::PROD_W-1:0] prod_q;
  logic signed [fbmvn_pkg::MUL_W-1:0]  rnd_q;
  logic        [fbmvn_pkg::PROD_W-1:0] rnd_sum;

  // round to nearest, ties away from zero, then drop the fraction
  assign rnd_sum = prod_q[fbmvn_pkg::PROD_W-1] ? (prod_q + HALF - 1'b1) : (prod_q + HALF);

  // product stage, then rounding stage
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    rnd_q  <= $signed(rnd_sum[fbmvn_pkg::FRAC_BITS +: fbmvn_pkg::MUL_W]);
  end

  assign prod_o = prod_q;
  assign rnd_o  = rnd_q;

endmodule

`default_nettype wire

// ===== design/fbmvn_div.sv =====
// restoring divider that normalizes the weighted octave sum, one quotient bit per cycle
`default_nettype none

module fbmvn_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fbmvn_pkg::div_req_t   req_i,
  output fbmvn_pkg::div_rsp_t        rsp_o
);

  localparam int DIV_W = fbmvn_pkg::ACC_W + fbmvn_pkg::QUO_W;
  localparam int DCNT_W = $clog2(fbmvn_pkg::QUO_W + 1);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [DCNT_W-1:0]                 cnt_q, cnt_d;
  logic [fbmvn_pkg::ACC_W-1:0]       rem_q, rem_d;
  logic [DIV_W-1:0]                  dsh_q, dsh_d;
  logic [fbmvn_pkg::QUO_W-1:0]       quo_q, quo_d;
  logic                              neg_q, neg_d;
  logic [fbmvn_pkg::ACC_W-1:0]       mag;
  logic                              ge;
  logic [fbmvn_pkg::QUO_W-1:0]       quo_sat;

  // magnitude of the sum; half the divisor is added to it at start for rounding
  assign mag = req_i.acc[fbmvn_pkg::ACC_W-1] ? fbmvn_pkg::ACC_W'(-req_i.acc)
                                             : fbmvn_pkg::ACC_W'(req_i.acc);
  assign ge  = DIV_W'(rem_q) >= dsh_q;

  // next state of the iteration
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(fbmvn_pkg::QUO_W);
      rem_d  = mag + fbmvn_pkg::ACC_W'(req_i.den >> 1);
      dsh_d  = DIV_W'(req_i.den) << (fbmvn_pkg::QUO_W - 1);
      quo_d  = '0;
      neg_d  = req_i.acc[fbmvn_pkg::ACC_W-1];
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - fbmvn_pkg::ACC_W'(dsh_q);
      end
      quo_d = {quo_q[fbmvn_pkg::QUO_W-2:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  // clamp to one, then apply the sign
  assign quo_sat = (quo_q > fbmvn_pkg::QUO_W'(fbmvn_pkg::ONE_Q)) ?
                   fbmvn_pkg::QUO_W'(fbmvn_pkg::ONE_Q) : quo_q;

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed(fbmvn_pkg::VAL_W'(quo_sat))
                            :  $signed(fbmvn_pkg::VAL_W'(quo_sat));

`ifndef ASSERT_OFF
  // a new division never starts on top of one in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("divider started while busy");

  // the last quotient bit is followed by exactly one done pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == DCNT_W'(1)) |=> (done_q && !busy_q))
    else $error("divider finished without done");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the fractal value noise block: random and corner items, predicted results
module tb;
  import fbmvn_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 250;
  localparam int RANDOM_ITEMS = 430;

  // expected noise per accepted item, checked in order against the output
  class noise_scoreboard;
    logic signed [VAL_W-1:0] expected_noise[$];
    int mismatches;
    int checked;

    // Q.F product, rounded to nearest with ties away from zero
    function longint mul_round(longint a, longint b);
      longint p;
      longint m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = (m + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      return (p < 0) ? -m : m;
    endfunction

    function longint div_nearest(longint a, longint d);
      longint m;
      m = (a < 0) ? -a : a;
      m = (m + d / 2) / d;
      return (a < 0) ? -m : m;
    endfunction

    // multiply-xorshift hash of one lattice corner
    function logic [31:0] lattice_mix(logic [31:0] xi, logic [31:0] yi, logic [31:0] seed);
      logic [31:0] h;
      h = xi * HASH_PX + yi * HASH_PY + seed * HASH_PS;
      h = (h ^ (h >> 13)) * HASH_PD;
      return h ^ (h >> 16);
    endfunction

    // low 31 hash bits mapped onto [-1,1], rounded half up
    function longint corner_level(logic [31:0] xi, logic [31:0] yi, logic [31:0] seed);
      logic [31:0] h;
      longint unsigned v;
      h = lattice_mix(xi, yi, seed);
      v = ((longint'({1'b0, h[30:0]}) << (FRAC_BITS + 1)) + 64'h3FFFFFFF) / 64'h7FFFFFFF;
      return longint'(v) - ONE_Q;
    endfunction

    // quintic fade, clamped to [0,1]
    function longint smooth_step(longint t);
      longint b;
      longint u;
      b = mul_round(t, 6 * t - 15 * ONE_Q) + 10 * ONE_Q;
      u = mul_round(t, mul_round(t, mul_round(t, b)));
      if (u < 0) u = 0;
      if (u > ONE_Q) u = ONE_Q;
      return u;
    endfunction

    // coordinate scaled by 2^sh, split into wrapped integer part and fraction
    function void split_lattice(input logic [31:0] c, input int sh,
                                output logic [31:0] ip, output longint fp);
      logic signed [63:0] u;
      u = $signed(c);
      u = u <<< sh;
      fp = longint'(u[FRAC_BITS-1:0]);
      ip = u[FRAC_BITS+31:FRAC_BITS];
    endfunction

    function longint octave_value(logic [31:0] x, logic [31:0] y, int sh, logic [31:0] seed);
      logic [31:0] xi, yi;
      longint xf, yf, n00, n10, n01, n11, u, v, nx0, nx1;
      split_lattice(x, sh, xi, xf);
      split_lattice(y, sh, yi, yf);
      n00 = corner_level(xi, yi, seed);
      n10 = corner_level(xi + 32'd1, yi, seed);
      n01 = corner_level(xi, yi + 32'd1, seed);
      n11 = corner_level(xi + 32'd1, yi + 32'd1, seed);
      u = smooth_step(xf);
      v = smooth_step(yf);
      nx0 = n00 + mul_round(n10 - n00, u);
      nx1 = n01 + mul_round(n11 - n01, u);
      return nx0 + mul_round(nx1 - nx0, v);
    endfunction

    // weighted octave sum normalized by the weights used
    function logic signed [VAL_W-1:0] fbm_noise(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] seed, logic [CNT_W-1:0] cnt);
      int n;
      longint acc, wsum, w, r;
      logic [31:0] oct_seed;
      n = cnt;
      if (n < 1) n = 1;
      if (n > MAX_OCTAVES) n = MAX_OCTAVES;
      acc = 0;
      wsum = 0;
      for (int i = 0; i < n; i++) begin
        w = longint'(1) << (MAX_OCTAVES - 1 - i);
        oct_seed = seed + SEED_STEP * 32'(i);
        acc += octave_value(x, y, i, oct_seed) * w;
        wsum += w;
      end
      r = div_nearest(acc, wsum);
      if (r > ONE_Q) r = ONE_Q;
      if (r < -ONE_Q) r = -ONE_Q;
      return VAL_W'(r);
    endfunction

    function void note_sample(logic [31:0] x, logic [31:0] y, logic [31:0] seed,
                              logic [CNT_W-1:0] cnt);
      expected_noise.push_back(fbm_noise(x, y, seed, cnt));
    endfunction

    function void check_noise(logic signed [VAL_W-1:0] got);
      logic signed [VAL_W-1:0] exp_val;
      if (expected_noise.size() == 0) begin
        $display("%0t: unexpected noise item, expected none, got %0d", $time, got);
        mismatches++;
      end else begin
        exp_val = expected_noise.pop_front();
        checked++;
        if (exp_val !== got) begin
          $display("%0t: noise mismatch, expected %0d, got %0d", $time, exp_val, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [COORD_W-1:0] x_coord_i = '0;
  logic signed [COORD_W-1:0] y_coord_i = '0;
  logic signed [SEED_W-1:0] noise_seed_i = '0;
  logic [CNT_W-1:0] octave_count_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [VAL_W-1:0] noise_value_o;

  noise_scoreboard sb;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;
  int samples_sent = 0;
  int zero_counts = 0;
  int over_counts = 0;

  fbm_value_noise_2d_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .x_coord_i,
    .y_coord_i,
    .noise_seed_i,
    .octave_count_i,
    .out_valid_o,
    .out_stall_i,
    .noise_value_o
  );

  always #5 clk_i = ~clk_i;

  // accepted items on both sides, plus the no-progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_sample(x_coord_i, y_coord_i, noise_seed_i, octave_count_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_noise(noise_value_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // output side stalls: short random ones, a few long ones, one forced hold
  initial begin
    int r;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req = 1'b0;
      end else if (quiet) begin
        out_stall_i = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        out_stall_i = (r >= 60);
        if (r >= 97) repeat ($urandom_range(20, 80)) @(negedge clk_i);
      end
    end
  end

  // offer one item after a random gap and hold it until accepted
  task automatic send_sample(logic [31:0] x, logic [31:0] y, logic [31:0] seed,
                             logic [CNT_W-1:0] cnt);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = quiet ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(15, 60);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    x_coord_i = x;
    y_coord_i = y;
    noise_seed_i = seed;
    octave_count_i = cnt;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    samples_sent++;
    if (cnt == 0) zero_counts++;
    if (cnt > MAX_OCTAVES) over_counts++;
  endtask

  // whole range, small coordinates near the origin, or near the signed limits
  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    case ($urandom_range(0, 3))
      0, 1: c = $urandom();
      2: c = {16'($urandom_range(0, 63)) - 16'd32, 16'($urandom())};
      default: c = {($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000, 16'($urandom())};
    endcase
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return CNT_W'($urandom_range(1, MAX_OCTAVES));
    if (r == 8) return '0;
    return CNT_W'($urandom_range(MAX_OCTAVES + 1, 15));
  endfunction

  initial begin
    logic [31:0] seed;
    sb = new;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // origin, signed limits and lattice wrap at the highest octave
    send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 4'd1);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd8);
    send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 4'd8);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 4'd15);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_F000, 4'd0);
    send_sample(32'h00FF_FFFF, 32'hFF00_0001, 32'hFFFF_F000, 4'd8);
    // fraction extremes
    send_sample(32'h0000_FFFF, 32'h0001_0000, 32'h1234_5678, 4'd1);
    send_sample(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001, 4'd2);
    send_sample(32'hFFFF_0000, 32'h0000_0001, 32'h8000_0000, 4'd3);
    // octave counts zero to ten plus 12 and 14, including zero and saturated ones
    for (int c = 0; c < 16; c++) begin
      if (c % 2 == 0 || c < MAX_OCTAVES + 2) begin
        send_sample($urandom(), $urandom(), $urandom(), CNT_W'(c));
      end
    end

    // random part; a quiet stretch and one long output hold in the middle
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 120) hold_req = 1'b1;
      quiet = (k >= 220 && k < 270);
      seed = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FC00 + $urandom_range(0, 1023) : $urandom();
      send_sample(rand_coord(), rand_coord(), seed, rand_count());
    end
    in_valid_i = 1'b0;

    while (sb.expected_noise.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d items, %0d results checked, one long output hold",
             samples_sent, sb.checked);
    $display("octave count zero in %0d items, above eight in %0d items",
             zero_counts, over_counts);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
